// ===== rtl/core/rc_pkg.sv =====
package rc_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int MAX_DIGITS  = 32;
    localparam int BASE_WIDTH  = 6;
    localparam int CHAR_WIDTH  = 7;
    localparam int BASE_MIN    = 2;
    localparam int BASE_MAX    = 36;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_LOAD,
        S_SEND
    } t_state;

    // digit value 0..35 to ascii '0'-'9', 'A'-'Z'
    function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [BASE_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] d_ext;
        d_ext = CHAR_WIDTH'(d);
        if (d < BASE_WIDTH'(10)) begin
            return CHAR_WIDTH'(48) + d_ext;
        end
        return CHAR_WIDTH'(55) + d_ext;
    endfunction

endpackage

// ===== rtl/core/rc_stream_if.sv =====
interface rc_in_if #(
    parameter int VALUE_WIDTH = rc_pkg::VALUE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic [VALUE_WIDTH-1:0]         value;
    logic [rc_pkg::BASE_WIDTH-1:0]  base;

    modport source (output valid, output value, output base, input ready);
    modport sink   (input valid, input value, input base, output ready);
endinterface

interface rc_out_if;
    logic                           valid;
    logic                           ready;
    logic [rc_pkg::CHAR_WIDTH-1:0]  digit_char;
    logic                           last;
    logic                           bad_base;

    modport source (output valid, output digit_char, output last, output bad_base, input ready);
    modport sink   (input valid, input digit_char, input last, input bad_base, output ready);
endinterface

// ===== rtl/core/radix_converter.sv =====
// radix_converter: takes one beat {value, base} and returns the digits of value in that
// base, most significant first, one beat per digit as an ascii character '0'-'9' or
// 'A'-'Z', with last set on the final digit. a zero value gives the single digit '0'.
// a base outside 2..36 gives one beat with bad_base and last set and digit_char zero.
// digits come from a shared restoring shift-subtract divider that retires one quotient
// bit per cycle; the remainders go into a small digit ram and are read back with one
// registered read per digit. the block takes no new beat until the last digit has left.
// only the low MAX_DIGITS digits are kept if a value has more.
module radix_converter #(
    parameter int VALUE_WIDTH = rc_pkg::VALUE_WIDTH,
    parameter int MAX_DIGITS  = rc_pkg::MAX_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rc_in_if.sink       i_in,
    rc_out_if.source    o_out
);

    localparam int BW  = rc_pkg::BASE_WIDTH;
    localparam int CHW = rc_pkg::CHAR_WIDTH;
    localparam int AW  = $clog2(MAX_DIGITS);      // digit ram address
    localparam int CW  = $clog2(MAX_DIGITS + 1);  // digit count, holds MAX_DIGITS
    localparam int TW  = $clog2(VALUE_WIDTH);     // divider bit counter

    rc_pkg::t_state r_state, n_state;

    logic [VALUE_WIDTH-1:0] r_work, n_work;   // dividend shifting out, quotient shifting in
    logic [BW-1:0]          r_rem,  n_rem;    // partial remainder
    logic [BW-1:0]          r_base, n_base;
    logic [TW-1:0]          r_bit,  n_bit;
    logic [CW-1:0]          r_cnt,  n_cnt;
    logic [AW-1:0]          r_idx,  n_idx;
    logic                   r_out_valid, n_out_valid;
    logic [CHW-1:0]         r_char, n_char;
    logic                   r_last, n_last;
    logic                   r_bad,  n_bad;

    // divider step
    logic [BW:0]            rem_sh;
    logic                   rem_ge;
    logic [BW-1:0]          rem_new;
    logic [VALUE_WIDTH-1:0] work_new;
    logic [CW-1:0]          cnt_inc;

    // digit ram port
    logic          ram_we;
    logic          ram_re;
    logic [BW-1:0] ram_rdata;

    always_comb begin
        rem_sh   = {r_rem, r_work[VALUE_WIDTH-1]};
        rem_ge   = rem_sh >= {1'b0, r_base};
        rem_new  = rem_ge ? BW'(rem_sh - {1'b0, r_base}) : rem_sh[BW-1:0];
        work_new = {r_work[VALUE_WIDTH-2:0], rem_ge};
        // count saturates when the store is full
        cnt_inc  = (r_cnt < CW'(MAX_DIGITS)) ? r_cnt + CW'(1) : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_base <= n_base;
        r_bit  <= n_bit;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
        r_bad  <= n_bad;
    end

    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_rem       = r_rem;
        n_base      = r_base;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        n_bad       = r_bad;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        case (r_state)
            rc_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_cnt = '0;
                    if (i_in.base inside {[rc_pkg::BASE_MIN:rc_pkg::BASE_MAX]}) begin
                        n_work  = i_in.value;
                        n_base  = i_in.base;
                        n_rem   = '0;
                        n_bit   = TW'(VALUE_WIDTH - 1);
                        n_state = rc_pkg::S_DIV;
                    end else begin
                        // error beat, no division
                        n_char      = '0;
                        n_last      = 1'b1;
                        n_bad       = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = rc_pkg::S_SEND;
                    end
                end
            end
            rc_pkg::S_DIV: begin
                n_rem  = rem_new;
                n_work = work_new;
                n_bit  = r_bit - TW'(1);
                if (r_bit == '0) begin
                    // quotient and remainder complete: store the digit
                    ram_we = r_cnt < CW'(MAX_DIGITS);
                    n_cnt  = cnt_inc;
                    if (work_new == '0) begin
                        // zero value lands here after one pass with digit 0
                        n_idx   = AW'(cnt_inc - CW'(1));
                        n_state = rc_pkg::S_READ;
                    end else begin
                        n_rem = '0;
                        n_bit = TW'(VALUE_WIDTH - 1);
                    end
                end
            end
            rc_pkg::S_READ: begin
                ram_re  = 1'b1;
                n_state = rc_pkg::S_LOAD;
            end
            rc_pkg::S_LOAD: begin
                n_char      = rc_pkg::digit_to_ascii(ram_rdata);
                n_last      = r_idx == '0;
                n_bad       = 1'b0;
                n_out_valid = 1'b1;
                n_state     = rc_pkg::S_SEND;
            end
            rc_pkg::S_SEND: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_last) begin
                        n_state = rc_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = rc_pkg::S_READ;
                    end
                end
            end
            default: begin
                n_state     = rc_pkg::S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    rc_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_DIGITS)
    ) u_digit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (rem_new),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready       = r_state == rc_pkg::S_IDLE;
    assign o_out.valid      = r_out_valid;
    assign o_out.digit_char = r_char;
    assign o_out.last       = r_last;
    assign o_out.bad_base   = r_bad;

    // no new beat taken while a digit is still pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !r_out_valid)
        else $error("input ready while a result beat is pending");

    // error beat is a single zero character that closes the run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.bad_base) |-> (o_out.last && o_out.digit_char == '0))
        else $error("bad base beat malformed");

    // partial remainder stays below the divisor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc_pkg::S_DIV) |-> ({1'b0, r_rem} < {1'b0, r_base}))
        else $error("divider remainder out of range");

    // digit count never passes the store depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_DIGITS))
        else $error("digit count overflow");

    // a delivered non-final digit leads to the next read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> (r_state == rc_pkg::S_READ))
        else $error("digit run broken");

endmodule

// ===== rtl/core/rc_ram.sv =====
module rc_ram #(
    parameter int WIDTH = rc_pkg::BASE_WIDTH,
    parameter int DEPTH = rc_pkg::MAX_DIGITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
